FILE: src/qph_pkg.sv
// ----------------------------------------------------------------------------
// qph_pkg
// Shared widths, operation and status codes, and types for the quadratic
// probing key table.
// ----------------------------------------------------------------------------
package qph_pkg;

   localparam int KEY_W    = 31;
   localparam int SIZE_W   = 9;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 8;
   localparam int CNT_W    = $clog2(KEY_W);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_HOME      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_COLLIDE   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd251;
   localparam logic [SIZE_W-1:0] SIZE_MIN   = 9'd2;

   typedef struct packed {
      logic              done;
      logic [SIZE_W-1:0] rem;
   } rem_sts_type;

endpackage

FILE: src/qph_ram.sv
// ----------------------------------------------------------------------------
// qph_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module qph_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/qph_rem.sv
// ----------------------------------------------------------------------------
// qph_rem
// Iterative restoring remainder: key mod table size, one key bit per cycle.
// ----------------------------------------------------------------------------
module qph_rem (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [qph_pkg::KEY_W-1:0]  dividend,
   input  logic [qph_pkg::SIZE_W-1:0] divisor,
   output qph_pkg::rem_sts_type       sts
);

   logic                       busy_ff,  busy_in;
   logic                       done_ff,  done_in;
   logic [qph_pkg::CNT_W-1:0]  cnt_ff,   cnt_in;
   logic [qph_pkg::SIZE_W-1:0] acc_ff,   acc_in;
   logic [qph_pkg::KEY_W-1:0]  dvd_ff,   dvd_in;
   logic [qph_pkg::SIZE_W-1:0] dvs_ff,   dvs_in;
   logic [qph_pkg::SIZE_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      trial   = {acc_ff, dvd_ff[qph_pkg::KEY_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = qph_pkg::CNT_W'(qph_pkg::KEY_W - 1);
         acc_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            trial = trial - {1'b0, dvs_ff};
         end
         acc_in = trial[qph_pkg::SIZE_W-1:0];
         dvd_in = {dvd_ff[qph_pkg::KEY_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign sts.done = done_ff;
   assign sts.rem  = acc_ff;

endmodule

FILE: src/quadratic_probe_hash_table.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressing key table, quadratic probing on insert; insert and remove
// of positive 31-bit keys, one item at a time under a small sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                            | tuser
//  req_    | in  | [30:0] key                       | [0] cmd
//  rsp_    | out | [2:0] status, [10:3] slot        | -
//  csr_    | in  | csr_wdata [8:0] table_size       | -
//
// Insert: the key is accepted, reduced mod size in the remainder unit, then
// probed quadratically from its home slot; remove scans the slots linearly
// from slot 0. The probe pipeline issues one slot memory read per cycle.
// After reset a clearing pass empties the slot memory; req_ is not ready
// meanwhile. A finished result waits in the rsp_ register.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table #(
   parameter int SLOTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [30:0] key
   input  logic        req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] status, [10:3] slot
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata    // [8:0] table_size
);

   localparam int AW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int SW = qph_pkg::SIZE_W;
   localparam int KW = qph_pkg::KEY_W;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_PROBE  = 3'd3;
   localparam logic [2:0] S_RESULT = 3'd4;

   logic [2:0]                      state_ff,    state_in;
   logic [SW-1:0]                   csr_size_ff;
   logic [AW-1:0]                   clr_addr_ff, clr_addr_in;
   logic                            cmd_ff,      cmd_in;
   logic [KW-1:0]                   key_ff,      key_in;
   logic [SW-1:0]                   size_ff,     size_in;
   logic [SW-1:0]                   pos_ff,      pos_in;
   logic [SW-1:0]                   inc_ff,      inc_in;
   logic [SW-1:0]                   n_iss_ff,    n_iss_in;
   logic                            rd_vld_ff,   rd_vld_in;
   logic                            rd_first_ff, rd_first_in;
   logic                            rd_last_ff,  rd_last_in;
   logic [SW-1:0]                   rd_addr_ff,  rd_addr_in;
   logic [CW-1:0]                   count_ff,    count_in;
   logic [qph_pkg::STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [qph_pkg::SLOT_W-1:0]      res_slot_ff,   res_slot_in;
   logic                            rsp_tvalid_ff, rsp_tvalid_in;
   logic [qph_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [qph_pkg::SLOT_W-1:0]      rsp_slot_ff,   rsp_slot_in;

   logic [SW-1:0]          eff_size;
   logic                   accept;
   logic                   rem_start;
   qph_pkg::rem_sts_type   rem_sts;
   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   logic [KW-1:0]          ram_wdata;
   logic [KW-1:0]          ram_rdata;
   logic                   issue;
   logic                   hit;
   logic [SW:0]            pos_sum;
   logic [SW:0]            inc_sum;
   logic [KW-1:0]          req_key;

   assign req_key    = req_tdata[KW-1:0];
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      eff_size = csr_size_ff;
      if (csr_size_ff < qph_pkg::SIZE_MIN) begin
         eff_size = qph_pkg::SIZE_MIN;
      end
      if (32'(csr_size_ff) > 32'(SLOTS)) begin
         eff_size = SW'(SLOTS);
      end
   end

   assign rem_start = accept && (req_tuser == qph_pkg::CMD_INSERT) && (req_key != '0)
                      && (32'(count_ff) < 32'(eff_size));

   qph_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (req_key),
      .divisor  (eff_size),
      .sts      (rem_sts)
   );

   qph_ram #(
      .WIDTH (KW),
      .DEPTH (SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (AW'(pos_ff)),
      .rd_data (ram_rdata)
   );

   assign issue   = (n_iss_ff < size_ff);
   assign hit     = rd_vld_ff && ((cmd_ff == qph_pkg::CMD_INSERT) ? (ram_rdata == '0)
                                                                  : (ram_rdata == key_ff));
   assign pos_sum = {1'b0, pos_ff} + {1'b0, inc_ff};
   assign inc_sum = {1'b0, inc_ff} + (SW + 1)'(2);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      size_in       = size_ff;
      pos_in        = pos_ff;
      inc_in        = inc_ff;
      n_iss_in      = n_iss_ff;
      rd_vld_in     = 1'b0;
      rd_first_in   = 1'b0;
      rd_last_in    = 1'b0;
      rd_addr_in    = pos_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      ram_we        = 1'b0;
      ram_waddr     = AW'(rd_addr_ff);
      ram_wdata     = '0;

      case (state_ff)
         S_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_tuser;
               key_in   = req_key;
               size_in  = eff_size;
               pos_in   = '0;
               inc_in   = SW'(1);
               n_iss_in = '0;
               if (req_key == '0) begin
                  res_status_in = qph_pkg::ST_NOT_FOUND;
                  res_slot_in   = '0;
                  state_in      = S_RESULT;
               end else if (req_tuser == qph_pkg::CMD_REMOVE) begin
                  state_in = S_PROBE;
               end else if (32'(count_ff) >= 32'(eff_size)) begin
                  res_status_in = qph_pkg::ST_FULL;
                  res_slot_in   = '0;
                  state_in      = S_RESULT;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (rem_sts.done) begin
               pos_in   = rem_sts.rem;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (hit) begin
               ram_we      = 1'b1;
               res_slot_in = qph_pkg::SLOT_W'(rd_addr_ff);
               state_in    = S_RESULT;
               if (cmd_ff == qph_pkg::CMD_INSERT) begin
                  ram_wdata     = key_ff;
                  count_in      = count_ff + 1'b1;
                  res_status_in = rd_first_ff ? qph_pkg::ST_HOME : qph_pkg::ST_COLLIDE;
               end else begin
                  res_status_in = qph_pkg::ST_REMOVED;
                  if (count_ff != '0) begin
                     count_in = count_ff - 1'b1;
                  end
               end
            end else if (rd_vld_ff && rd_last_ff) begin
               res_status_in = qph_pkg::ST_NOT_FOUND;
               res_slot_in   = '0;
               state_in      = S_RESULT;
            end else if (issue) begin
               rd_vld_in   = 1'b1;
               rd_first_in = (n_iss_ff == '0);
               rd_last_in  = (n_iss_ff == size_ff - 1'b1);
               n_iss_in    = n_iss_ff + 1'b1;
               pos_in      = (pos_sum >= {1'b0, size_ff}) ? SW'(pos_sum - {1'b0, size_ff})
                                                          : SW'(pos_sum);
               if (cmd_ff == qph_pkg::CMD_INSERT) begin
                  inc_in = (inc_sum >= {1'b0, size_ff}) ? SW'(inc_sum - {1'b0, size_ff})
                                                        : SW'(inc_sum);
               end
            end
         end
         S_RESULT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         csr_size_ff   <= qph_pkg::SIZE_RESET;
         clr_addr_ff   <= '0;
         count_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         count_ff      <= count_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_we) begin
            csr_size_ff <= csr_wdata;
         end
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      size_ff       <= size_in;
      pos_ff        <= pos_in;
      inc_ff        <= inc_in;
      n_iss_ff      <= n_iss_in;
      rd_first_ff   <= rd_first_in;
      rd_last_ff    <= rd_last_in;
      rd_addr_ff    <= rd_addr_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {5'b0, rsp_slot_ff, rsp_status_ff};

endmodule

FILE: src/qph_checker.sv
// ----------------------------------------------------------------------------
// qph_checker
// Port-level checks on the quadratic probing key table, bound to the top.
// ----------------------------------------------------------------------------
module qph_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("req_tready high during clearing pass");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("new request taken while one is in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] <= qph_pkg::ST_NOT_FOUND && rsp_tdata[15:11] == 5'b0))
      else $error("response status out of range");

   a_no_change_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[2:0] == qph_pkg::ST_FULL ||
                      rsp_tdata[2:0] == qph_pkg::ST_NOT_FOUND)) |-> (rsp_tdata[10:3] == 8'b0))
      else $error("slot not zero on unchanged result");

endmodule

bind quadratic_probe_hash_table qph_checker u_qph_checker (.*);
